/* hw/rtl/rmdt_pkg.sv */
// Shared types and codes for the register/memory data transfer unit.
`default_nettype none

package rmdt_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int NUM_REGS      = 7;

  localparam logic [3:0] OP_MOV  = 4'd0;
  localparam logic [3:0] OP_MVI  = 4'd1;
  localparam logic [3:0] OP_LDA  = 4'd2;
  localparam logic [3:0] OP_STA  = 4'd3;
  localparam logic [3:0] OP_SET  = 4'd4;
  localparam logic [3:0] OP_SHLD = 4'd5;
  localparam logic [3:0] OP_LHLD = 4'd6;
  localparam logic [3:0] OP_XCHG = 4'd7;
  localparam logic [3:0] OP_LXI  = 4'd8;
  localparam logic [3:0] OP_STAX = 4'd9;

  localparam logic [2:0] REG_A    = 3'd0;
  localparam logic [2:0] REG_B    = 3'd1;
  localparam logic [2:0] REG_C    = 3'd2;
  localparam logic [2:0] REG_D    = 3'd3;
  localparam logic [2:0] REG_E    = 3'd4;
  localparam logic [2:0] REG_H    = 3'd5;
  localparam logic [2:0] REG_L    = 3'd6;
  localparam logic [2:0] REG_NONE = 3'd7;

  localparam logic [1:0] PAIR_BC   = 2'd0;
  localparam logic [1:0] PAIR_DE   = 2'd1;
  localparam logic [1:0] PAIR_HL   = 2'd2;
  localparam logic [1:0] PAIR_NONE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_REG  = 2'd1;
  localparam logic [1:0] ST_LOW_ADDR = 2'd2;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [2:0]  dest_reg;
    logic [2:0]  src_reg;
    logic [1:0]  pair_sel;
    logic [7:0]  data_byte;
    logic [15:0] address_or_word;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] reg_a;
    logic [7:0] reg_b;
    logic [7:0] reg_c;
    logic [7:0] reg_d;
    logic [7:0] reg_e;
    logic [7:0] reg_h;
    logic [7:0] reg_l;
  } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/rmdt_ram.sv */
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none

module rmdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/register_memory_data_transfer_unit.sv */
// Top level: 8085-style data transfer unit, register file plus byte memory.
//
//   channel | dir | handshake             | word
//   cfg     | in  | cfg_valid/cfg_ready   | cfg_data, start_address
//   cmd     | in  | cmd_valid/cmd_stall   | cmd (rmdt_pkg::cmd_t)
//   rsp     | out | rsp_valid/rsp_stall   | rsp (rmdt_pkg::rsp_t)
//
// Each command holds the execute stage for a first and a second phase, set by the
// single ports of the byte memory (SHLD/LHLD touch two bytes); while busy, a new
// command is taken only as the previous one finishes and registers its result.
// After rst the memory is zeroed, one byte per cycle, over all 2**ADDR_BITS bytes
// (65536 by default) with cmd_stall high; cfg writes are taken throughout.
// A stalled rsp holds the command in its second phase until the slot frees.
`default_nettype none

module register_memory_data_transfer_unit #(
  parameter int ADDR_BITS = rmdt_pkg::ADDR_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [15:0]    cfg_data,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire rmdt_pkg::cmd_t cmd,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output rmdt_pkg::rsp_t      rsp
);

  localparam int MEM_DEPTH = 2 ** ADDR_BITS;

  logic [15:0]          start_address;
  logic [7:0]           rf      [rmdt_pkg::NUM_REGS];
  logic [7:0]           rf_next [rmdt_pkg::NUM_REGS];
  logic                 clearing;
  logic [ADDR_BITS-1:0] clr_addr;
  logic                 busy;
  logic                 phase;
  rmdt_pkg::cmd_t       work;
  logic [7:0]           rd_lo;
  logic                 fwd_hit;
  logic [7:0]           fwd_data;
  logic [7:0]           ram_rdata;
  logic [7:0]           rd_byte;
  logic                 we;
  logic [ADDR_BITS-1:0] waddr;
  logic [ADDR_BITS-1:0] raddr;
  logic [7:0]           wdata;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] addr_inc;
  logic [15:0]          pair_word;
  logic [ADDR_BITS-1:0] pair_addr;
  logic                 cmd_accept;
  logic                 rsp_free;
  logic                 first;
  logic                 finish;
  logic [1:0]           status;

  assign cfg_ready  = 1'b1;
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign first      = busy && !phase;
  assign finish     = busy && phase && rsp_free;
  assign cmd_stall  = clearing || (busy && !(phase && rsp_free));
  assign cmd_accept = cmd_valid && !cmd_stall;

  assign addr     = work.address_or_word[ADDR_BITS-1:0];
  assign addr_inc = addr + 1'b1;

  always_comb begin
    unique case (work.pair_sel)
      rmdt_pkg::PAIR_BC: pair_word = {rf[rmdt_pkg::REG_B], rf[rmdt_pkg::REG_C]};
      rmdt_pkg::PAIR_DE: pair_word = {rf[rmdt_pkg::REG_D], rf[rmdt_pkg::REG_E]};
      default:           pair_word = {rf[rmdt_pkg::REG_H], rf[rmdt_pkg::REG_L]};
    endcase
  end
  assign pair_addr = pair_word[ADDR_BITS-1:0];

  // first read at acceptance, second byte (addr+1) read during the first phase
  assign raddr   = (busy && (!phase || !rsp_free)) ? addr_inc
                                                   : cmd.address_or_word[ADDR_BITS-1:0];
  assign rd_byte = fwd_hit ? fwd_data : ram_rdata;

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = rf[rmdt_pkg::REG_A];
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (first) begin
      unique case (work.opcode)
        rmdt_pkg::OP_STA: begin
          we = 1'b1;
        end
        rmdt_pkg::OP_SET: begin
          we    = 16'(addr) >= start_address;
          wdata = work.data_byte;
        end
        rmdt_pkg::OP_SHLD: begin
          we    = 1'b1;
          wdata = rf[rmdt_pkg::REG_L];
        end
        rmdt_pkg::OP_STAX: begin
          we    = work.pair_sel != rmdt_pkg::PAIR_NONE;
          waddr = pair_addr;
        end
        default: begin
        end
      endcase
    end else if (finish && work.opcode == rmdt_pkg::OP_SHLD) begin
      we    = 1'b1;
      waddr = addr_inc;
      wdata = rf[rmdt_pkg::REG_H];
    end
  end

  always_comb begin
    rf_next = rf;
    status  = rmdt_pkg::ST_OK;
    unique case (work.opcode)
      rmdt_pkg::OP_MOV: begin
        if (work.src_reg == rmdt_pkg::REG_NONE || work.dest_reg == rmdt_pkg::REG_NONE) begin
          status = rmdt_pkg::ST_BAD_REG;
        end else begin
          rf_next[work.dest_reg] = rf[work.src_reg];
        end
      end
      rmdt_pkg::OP_MVI: begin
        if (work.dest_reg == rmdt_pkg::REG_NONE) begin
          status = rmdt_pkg::ST_BAD_REG;
        end else begin
          rf_next[work.dest_reg] = work.data_byte;
        end
      end
      rmdt_pkg::OP_LDA: begin
        rf_next[rmdt_pkg::REG_A] = rd_lo;
      end
      rmdt_pkg::OP_SET: begin
        if (16'(addr) < start_address) begin
          status = rmdt_pkg::ST_LOW_ADDR;
        end
      end
      rmdt_pkg::OP_LHLD: begin
        rf_next[rmdt_pkg::REG_L] = rd_lo;
        rf_next[rmdt_pkg::REG_H] = rd_byte;
      end
      rmdt_pkg::OP_XCHG: begin
        rf_next[rmdt_pkg::REG_H] = rf[rmdt_pkg::REG_D];
        rf_next[rmdt_pkg::REG_D] = rf[rmdt_pkg::REG_H];
        rf_next[rmdt_pkg::REG_L] = rf[rmdt_pkg::REG_E];
        rf_next[rmdt_pkg::REG_E] = rf[rmdt_pkg::REG_L];
      end
      rmdt_pkg::OP_LXI: begin
        unique case (work.pair_sel)
          rmdt_pkg::PAIR_BC: begin
            rf_next[rmdt_pkg::REG_B] = work.address_or_word[15:8];
            rf_next[rmdt_pkg::REG_C] = work.address_or_word[7:0];
          end
          rmdt_pkg::PAIR_DE: begin
            rf_next[rmdt_pkg::REG_D] = work.address_or_word[15:8];
            rf_next[rmdt_pkg::REG_E] = work.address_or_word[7:0];
          end
          rmdt_pkg::PAIR_HL: begin
            rf_next[rmdt_pkg::REG_H] = work.address_or_word[15:8];
            rf_next[rmdt_pkg::REG_L] = work.address_or_word[7:0];
          end
          default: begin
            status = rmdt_pkg::ST_BAD_REG;
          end
        endcase
      end
      rmdt_pkg::OP_STAX: begin
        if (work.pair_sel == rmdt_pkg::PAIR_NONE) begin
          status = rmdt_pkg::ST_BAD_REG;
        end
      end
      default: begin
      end
    endcase
  end

  rmdt_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0;
      rf            <= '{default: '0};
      clearing      <= 1'b1;
      clr_addr      <= '0;
      busy          <= 1'b0;
      phase         <= 1'b0;
      fwd_hit       <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_address <= cfg_data;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) begin
          clearing <= 1'b0;
        end
      end
      // write and read of one byte at the same edge: RAM returns old data
      fwd_hit <= we && (waddr == raddr);
      if (cmd_accept) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end else if (first) begin
        phase <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        rf <= rf_next;
      end
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wdata;
    if (cmd_accept) begin
      work <= cmd;
    end
    if (first) begin
      rd_lo <= rd_byte;
    end
    if (finish) begin
      rsp.status <= status;
      rsp.reg_a  <= rf_next[rmdt_pkg::REG_A];
      rsp.reg_b  <= rf_next[rmdt_pkg::REG_B];
      rsp.reg_c  <= rf_next[rmdt_pkg::REG_C];
      rsp.reg_d  <= rf_next[rmdt_pkg::REG_D];
      rsp.reg_e  <= rf_next[rmdt_pkg::REG_E];
      rsp.reg_h  <= rf_next[rmdt_pkg::REG_H];
      rsp.reg_l  <= rf_next[rmdt_pkg::REG_L];
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd_accept |=> (busy && !phase))
    else $error("accepted command did not enter its first cycle");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    finish |=> rsp_valid)
    else $error("finished command produced no result");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!busy && cmd_stall))
    else $error("command in flight during memory clear");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

/* dv/rmdt_transfer_checker.sv */
// Checker for the data transfer unit: mirrors registers and memory, compares each response word.
module rmdt_transfer_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [15:0]     cfg_data,
  input  logic            cmd_valid,
  input  logic            cmd_stall,
  input  rmdt_pkg::cmd_t  cmd,
  input  logic            rsp_valid,
  input  logic            rsp_stall,
  input  rmdt_pkg::rsp_t  rsp,
  output int              errors,
  output int              pending
);

  logic [7:0]     regs [0:rmdt_pkg::NUM_REGS-1];
  logic [7:0]     mem [0:65535];
  logic [15:0]    start_addr;
  rmdt_pkg::rsp_t awaited_rsp [$];
  int             fail_count = 0;

  function automatic rmdt_pkg::rsp_t execute_transfer(rmdt_pkg::cmd_t c);
    rmdt_pkg::rsp_t r;
    logic [1:0]     st;
    logic [15:0]    a;
    logic [15:0]    nxt;
    logic [2:0]     hi;
    logic [7:0]     t;
    st  = rmdt_pkg::ST_OK;
    a   = c.address_or_word;
    nxt = a + 16'd1;
    hi  = rmdt_pkg::REG_B + {c.pair_sel, 1'b0};
    case (c.opcode)
      rmdt_pkg::OP_MOV: begin
        if (c.src_reg == rmdt_pkg::REG_NONE || c.dest_reg == rmdt_pkg::REG_NONE)
          st = rmdt_pkg::ST_BAD_REG;
        else regs[c.dest_reg] = regs[c.src_reg];
      end
      rmdt_pkg::OP_MVI: begin
        if (c.dest_reg == rmdt_pkg::REG_NONE) st = rmdt_pkg::ST_BAD_REG;
        else regs[c.dest_reg] = c.data_byte;
      end
      rmdt_pkg::OP_LDA: regs[rmdt_pkg::REG_A] = mem[a];
      rmdt_pkg::OP_STA: mem[a] = regs[rmdt_pkg::REG_A];
      rmdt_pkg::OP_SET: begin
        if (a < start_addr) st = rmdt_pkg::ST_LOW_ADDR;
        else mem[a] = c.data_byte;
      end
      rmdt_pkg::OP_SHLD: begin
        mem[a]   = regs[rmdt_pkg::REG_L];
        mem[nxt] = regs[rmdt_pkg::REG_H];
      end
      rmdt_pkg::OP_LHLD: begin
        regs[rmdt_pkg::REG_L] = mem[a];
        regs[rmdt_pkg::REG_H] = mem[nxt];
      end
      rmdt_pkg::OP_XCHG: begin
        t = regs[rmdt_pkg::REG_H];
        regs[rmdt_pkg::REG_H] = regs[rmdt_pkg::REG_D];
        regs[rmdt_pkg::REG_D] = t;
        t = regs[rmdt_pkg::REG_L];
        regs[rmdt_pkg::REG_L] = regs[rmdt_pkg::REG_E];
        regs[rmdt_pkg::REG_E] = t;
      end
      rmdt_pkg::OP_LXI: begin
        if (c.pair_sel == rmdt_pkg::PAIR_NONE) begin
          st = rmdt_pkg::ST_BAD_REG;
        end else begin
          regs[hi]        = c.address_or_word[15:8];
          regs[hi + 3'd1] = c.address_or_word[7:0];
        end
      end
      rmdt_pkg::OP_STAX: begin
        if (c.pair_sel == rmdt_pkg::PAIR_NONE) st = rmdt_pkg::ST_BAD_REG;
        else mem[{regs[hi], regs[hi + 3'd1]}] = regs[rmdt_pkg::REG_A];
      end
      default: ;
    endcase
    r.status = st;
    r.reg_a  = regs[rmdt_pkg::REG_A];
    r.reg_b  = regs[rmdt_pkg::REG_B];
    r.reg_c  = regs[rmdt_pkg::REG_C];
    r.reg_d  = regs[rmdt_pkg::REG_D];
    r.reg_e  = regs[rmdt_pkg::REG_E];
    r.reg_h  = regs[rmdt_pkg::REG_H];
    r.reg_l  = regs[rmdt_pkg::REG_L];
    return r;
  endfunction

  function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    rmdt_pkg::rsp_t want;
    if (rst) begin
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      start_addr = '0;
      awaited_rsp.delete();
    end else begin
      if (cfg_valid && cfg_ready) start_addr = cfg_data;
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: unexpected response word %h", $time, rsp);
          fail_count++;
        end else begin
          want = awaited_rsp.pop_front();
          fail_count += field_diff("status", 8'(want.status), 8'(rsp.status));
          fail_count += field_diff("reg_a", want.reg_a, rsp.reg_a);
          fail_count += field_diff("reg_b", want.reg_b, rsp.reg_b);
          fail_count += field_diff("reg_c", want.reg_c, rsp.reg_c);
          fail_count += field_diff("reg_d", want.reg_d, rsp.reg_d);
          fail_count += field_diff("reg_e", want.reg_e, rsp.reg_e);
          fail_count += field_diff("reg_h", want.reg_h, rsp.reg_h);
          fail_count += field_diff("reg_l", want.reg_l, rsp.reg_l);
        end
      end
      if (cmd_valid && !cmd_stall) awaited_rsp = {awaited_rsp, execute_transfer(cmd)};
    end
    errors  <= fail_count;
    pending <= awaited_rsp.size();
  end

endmodule

/* dv/register_memory_data_transfer_unit_test.sv */
// Testbench top for the data transfer unit: clock, reset, stimulus and verdict.
module register_memory_data_transfer_unit_test;

  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_ITEMS = 180;
  localparam int HOLD_CYCLES = 300;

  logic           clk;
  logic           rst;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [15:0]    cfg_data;
  logic           cmd_valid;
  logic           cmd_stall;
  rmdt_pkg::cmd_t cmd;
  logic           rsp_valid;
  logic           rsp_stall;
  rmdt_pkg::rsp_t rsp;
  int             errors;
  int             pending;
  int             cycle_count = 0;
  int             idle_pct = 29;
  int             stall_pct = 51;
  int             holds_asked = 0;
  int             holds_done = 0;
  int             hold_left = 0;

  register_memory_data_transfer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  rmdt_transfer_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // response side: random stall, or a long hold-off when asked
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic rmdt_pkg::cmd_t op_cmd(logic [3:0] op, logic [2:0] dst, logic [2:0] src,
                                            logic [1:0] pr, logic [7:0] db, logic [15:0] aw);
    rmdt_pkg::cmd_t c;
    c.opcode          = op;
    c.dest_reg        = dst;
    c.src_reg         = src;
    c.pair_sel        = pr;
    c.data_byte       = db;
    c.address_or_word = aw;
    return c;
  endfunction

  // most addresses fall in a 16-byte window so stores and loads meet
  function automatic rmdt_pkg::cmd_t random_transfer(logic [15:0] base);
    rmdt_pkg::cmd_t c;
    if ($urandom_range(99) < 6) c.opcode = rmdt_pkg::OP_STAX + 4'($urandom_range(1, 6));
    else c.opcode = 4'($urandom_range(rmdt_pkg::OP_MOV, rmdt_pkg::OP_STAX));
    c.dest_reg  = ($urandom_range(99) < 8) ? rmdt_pkg::REG_NONE
                : 3'($urandom_range(rmdt_pkg::REG_A, rmdt_pkg::REG_L));
    c.src_reg   = ($urandom_range(99) < 8) ? rmdt_pkg::REG_NONE
                : 3'($urandom_range(rmdt_pkg::REG_A, rmdt_pkg::REG_L));
    c.pair_sel  = ($urandom_range(99) < 8) ? rmdt_pkg::PAIR_NONE
                : 2'($urandom_range(rmdt_pkg::PAIR_BC, rmdt_pkg::PAIR_HL));
    c.data_byte = 8'($urandom);
    if ($urandom_range(99) < 80) c.address_or_word = base + 16'($urandom_range(0, 15));
    else c.address_or_word = 16'($urandom);
    return c;
  endfunction

  task automatic send_cmd(rmdt_pkg::cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_start(logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] start_val;
    logic [15:0] base;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_start(16'h0000);

    send_cmd(op_cmd(rmdt_pkg::OP_LDA, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'hFFFF));
    send_cmd(op_cmd(rmdt_pkg::OP_MVI, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'hFF, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_MVI, rmdt_pkg::REG_B, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_MVI, rmdt_pkg::REG_C, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h34, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_MVI, rmdt_pkg::REG_D, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h56, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_MVI, rmdt_pkg::REG_E, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h78, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_MVI, rmdt_pkg::REG_H, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h9A, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_MVI, rmdt_pkg::REG_L, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'hBC, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_MVI, rmdt_pkg::REG_NONE, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h11, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_MOV, rmdt_pkg::REG_B, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_MOV, rmdt_pkg::REG_C, rmdt_pkg::REG_NONE,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_MOV, rmdt_pkg::REG_NONE, rmdt_pkg::REG_L,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_STA, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'hFFFF));
    send_cmd(op_cmd(rmdt_pkg::OP_SHLD, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'hFFFF));
    send_cmd(op_cmd(rmdt_pkg::OP_LHLD, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'hFFFF));
    send_cmd(op_cmd(rmdt_pkg::OP_XCHG, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_LXI, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'hFFFF));
    send_cmd(op_cmd(rmdt_pkg::OP_LXI, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_DE, 8'h00, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_LXI, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_HL, 8'h00, 16'h1234));
    send_cmd(op_cmd(rmdt_pkg::OP_LXI, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_NONE, 8'h00, 16'h5555));
    send_cmd(op_cmd(rmdt_pkg::OP_STAX, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_STAX, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_DE, 8'h00, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_STAX, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_HL, 8'h00, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_STAX, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_NONE, 8'h00, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_SET, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h5A, 16'h0000));
    send_cmd(op_cmd(rmdt_pkg::OP_STAX + 4'd6, rmdt_pkg::REG_NONE, rmdt_pkg::REG_NONE,
                    rmdt_pkg::PAIR_NONE, 8'hFF, 16'hFFFF));
    send_cmd(op_cmd(rmdt_pkg::OP_STAX + 4'd1, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'h0000));

    drain();
    write_start(16'hFFFF);
    send_cmd(op_cmd(rmdt_pkg::OP_SET, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'hA5, 16'hFFFE));
    send_cmd(op_cmd(rmdt_pkg::OP_SET, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'hC3, 16'hFFFF));
    send_cmd(op_cmd(rmdt_pkg::OP_LDA, rmdt_pkg::REG_A, rmdt_pkg::REG_A,
                    rmdt_pkg::PAIR_BC, 8'h00, 16'hFFFF));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0:       start_val = 16'h0000;
        1:       start_val = 16'hFFFF;
        4:       start_val = 16'h8000;
        default: start_val = 16'($urandom);
      endcase
      write_start(start_val);
      base      = start_val - 16'd8;
      idle_pct  = (ph < 2) ? 29 : (ph < 4) ? 51 : 0;
      stall_pct = (ph < 2) ? 51 : (ph < 4) ? 29 : 0;
      if (ph == 1 || ph == 3) holds_asked++;
      for (int i = 0; i < PHASE_ITEMS; i++) send_cmd(random_transfer(base));
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
